// ===== design/esc_pkg.sv =====
`default_nettype none
package esc_pkg;
    // Register indexes on the configuration port
    localparam logic [2:0] REG_TEMP  = 3'd0;
    localparam logic [2:0] REG_PA    = 3'd1;
    localparam logic [2:0] REG_PB    = 3'd2;
    localparam logic [2:0] REG_PC    = 3'd3;
    localparam logic [2:0] REG_HUM   = 3'd4;

    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned DIV_STEPS = 32;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } t_raw;

    typedef struct packed {
        logic [23:0] temperature_centi;
        logic [31:0] pressure_pa;
        logic        pressure_invalid;
        logic [16:0] humidity_q10;
    } t_res;

    typedef struct packed {
        logic [47:0] tc;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [15:0] pc;
        logic [63:0] hc;
    } t_cal;

    function automatic logic [31:0] sar(input logic [31:0] v, input int s);
        sar = 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

// ===== design/esc_front.sv =====
`default_nettype none
// Front: register calibration, take raw frames into a short queue.
module esc_front
    import esc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_raw        i_raw,
    output t_cal             o_cal,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_raw             o_raw
);
    localparam int AW = $clog2(QDEPTH);
    t_cal r_cal;
    t_raw r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_cal   = r_cal;
    assign o_ready = (r_cnt != (AW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_raw   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Hold calibration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEMP: r_cal.tc <= i_cfg_data[47:0];
                REG_PA:   r_cal.pa <= i_cfg_data;
                REG_PB:   r_cal.pb <= i_cfg_data;
                REG_PC:   r_cal.pc <= i_cfg_data[15:0];
                REG_HUM:  r_cal.hc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_raw;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

// ===== design/esc_back.sv =====
`default_nettype none
// Back: pipelined compensation, one frame per cycle, stall on downstream.
// Stages: S0 temp products, S1 fine, S2 pressure/humidity terms,
// S3..S4 more terms, S5 divisor and dividend, S6..S7 dividend selection
// and humidity clamp, then a 32-step restoring divider, then the last
// quotient bit, the pressure correction and the output register.
module esc_back
    import esc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cal   i_cal,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_raw   i_raw,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_res        o_res
);
    localparam int NS = 11 + DIV_STEPS;
    logic w_adv;
    logic [NS-1:0] r_v;

    // Whole pipe moves together; it advances unless output is held
    assign w_adv   = !(o_valid && !i_ready);
    assign o_ready = w_adv;
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (w_adv) r_v <= {r_v[NS-2:0], i_valid};
    end

    // calibration fields
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, i_cal.tc[15:0]};
    assign t2 = sx16(i_cal.tc[31:16]);
    assign t3 = sx16(i_cal.tc[47:32]);
    assign p1 = {16'd0, i_cal.pa[15:0]};
    assign p2 = sx16(i_cal.pa[31:16]);
    assign p3 = sx16(i_cal.pa[47:32]);
    assign p4 = sx16(i_cal.pa[63:48]);
    assign p5 = sx16(i_cal.pb[15:0]);
    assign p6 = sx16(i_cal.pb[31:16]);
    assign p7 = sx16(i_cal.pb[47:32]);
    assign p8 = sx16(i_cal.pb[63:48]);
    assign p9 = sx16(i_cal.pc);
    assign h1 = {24'd0, i_cal.hc[7:0]};
    assign h2 = sx16(i_cal.hc[23:8]);
    assign h3 = {24'd0, i_cal.hc[31:24]};
    assign h4 = {{20{i_cal.hc[43]}}, i_cal.hc[43:32]};
    assign h5 = {{20{i_cal.hc[55]}}, i_cal.hc[55:44]};
    assign h6 = {{24{i_cal.hc[63]}}, i_cal.hc[63:56]};

    // S0: temperature products
    logic [19:0] r0_p; logic [15:0] r0_h; logic [31:0] r0_a, r0_dd;
    always_ff @(posedge i_clk) if (w_adv) begin
        r0_p  <= i_raw.raw_pressure;
        r0_h  <= i_raw.raw_humidity;
        r0_a  <= sar(((32'(i_raw.raw_temperature) >> 3) - (t1 << 1)) * t2, 11);
        r0_dd <= sar(((32'(i_raw.raw_temperature) >> 4) - t1)
                     * ((32'(i_raw.raw_temperature) >> 4) - t1), 12);
    end

    // S1: fine temperature
    logic [19:0] r1_p; logic [15:0] r1_h; logic [31:0] r1_f;
    always_ff @(posedge i_clk) if (w_adv) begin
        r1_p <= r0_p; r1_h <= r0_h;
        r1_f <= r0_a + sar(r0_dd * t3, 14);
    end

    // S2: first-level products
    logic [19:0] r2_p; logic [15:0] r2_h; logic [31:0] r2_q;
    logic [31:0] r2_a5, r2_a2, r2_hm, r2_h6, r2_h3, r2_t;
    logic [31:0] w1_a, w1_hm;
    assign w1_a  = sar(r1_f, 1) - 32'd64000;
    assign w1_hm = r1_f - 32'd76800;
    always_ff @(posedge i_clk) if (w_adv) begin
        r2_p <= r1_p; r2_h <= r1_h;
        r2_q <= sar(w1_a, 2) * sar(w1_a, 2);
        r2_a5 <= w1_a * p5;
        r2_a2 <= w1_a * p2;
        r2_hm <= w1_hm;
        r2_h6 <= sar(w1_hm * h6, 10);
        r2_h3 <= sar(w1_hm * h3, 11) + 32'd32768;
        r2_t  <= sar(r1_f * 32'd5 + 32'd128, 8);
    end

    // S3: second-level products
    logic [19:0] r3_p; logic [31:0] r3_t, r3_b, r3_a3, r3_a2, r3_hx, r3_hb;
    always_ff @(posedge i_clk) if (w_adv) begin
        r3_p  <= r2_p; r3_t <= r2_t;
        r3_b  <= sar(sar(r2_q, 11) * p6 + (r2_a5 << 1), 2) + (p4 << 16);
        r3_a3 <= sar(p3 * sar(r2_q, 13), 3);
        r3_a2 <= sar(r2_a2, 1);
        r3_hx <= sar(((32'(r2_h) << 14) - (h4 << 20) - (h5 * r2_hm)) + 32'd16384, 15);
        r3_hb <= sar(r2_h6 * r2_h3, 10) + 32'd2097152;
    end

    // S4: divisor base, humidity b
    logic [19:0] r4_p; logic [31:0] r4_t, r4_b, r4_d, r4_hx, r4_hb;
    always_ff @(posedge i_clk) if (w_adv) begin
        r4_p <= r3_p; r4_t <= r3_t; r4_b <= r3_b; r4_hx <= r3_hx;
        r4_d  <= 32'd32768 + sar(r3_a3 + r3_a2, 18);
        r4_hb <= sar(r3_hb * h2 + 32'd8192, 14);
    end

    // S5: divisor, dividend, humidity product
    logic [31:0] r5_t, r5_div, r5_num, r5_hum;
    always_ff @(posedge i_clk) if (w_adv) begin
        r5_t   <= r4_t;
        r5_div <= sar(r4_d * p1, 15);
        r5_num <= ((32'd1048576 - 32'(r4_p)) - sar(r4_b, 12)) * 32'd3125;
        r5_hum <= r4_hx * r4_hb;
    end

    // S6: humidity square term, dividend selection
    logic [31:0] r6_t, r6_div, r6_hum, r6_sq; logic [32:0] r6_n; logic r6_big;
    always_ff @(posedge i_clk) if (w_adv) begin
        r6_t <= r5_t; r6_div <= r5_div; r6_hum <= r5_hum;
        r6_sq <= sar(r5_hum, 15) * sar(r5_hum, 15);
        r6_big <= r5_num[31];
        r6_n <= r5_num[31] ? {1'b0, r5_num} : {r5_num, 1'b0};
    end

    // S7: humidity final and clamp
    logic [31:0] r7_t, r7_div; logic [32:0] r7_n; logic r7_big; logic [16:0] r7_hq;
    logic [31:0] w_h;
    assign w_h = r6_hum - sar(sar(r6_sq, 7) * h1, 4);
    always_ff @(posedge i_clk) if (w_adv) begin
        r7_t <= r6_t; r7_div <= r6_div; r7_n <= r6_n; r7_big <= r6_big;
        if (w_h[31])                  r7_hq <= '0;
        else if (w_h > 32'd419430400) r7_hq <= 17'd102400;
        else                          r7_hq <= w_h[28:12];
    end

    // Divider: one restoring step per stage, unsigned 33/32
    logic [32:0] r_dn [DIV_STEPS+1];
    logic [32:0] r_dr [DIV_STEPS+1];
    logic [31:0] r_dd [DIV_STEPS+1];
    logic [32:0] r_dq [DIV_STEPS+1];
    logic [31:0] r_dt [DIV_STEPS+1];
    logic [16:0] r_dh [DIV_STEPS+1];
    logic        r_db [DIV_STEPS+1];
    always_comb begin
        r_dn[0] = r7_n; r_dr[0] = '0; r_dd[0] = r7_div; r_dq[0] = '0;
        r_dt[0] = r7_t; r_dh[0] = r7_hq; r_db[0] = r7_big;
    end
    genvar g;
    generate for (g = 0; g < DIV_STEPS; g++) begin : g_div
        logic [33:0] w_r;
        assign w_r = {r_dr[g], r_dn[g][32-g]};
        always_ff @(posedge i_clk) if (w_adv) begin
            r_dn[g+1] <= r_dn[g]; r_dd[g+1] <= r_dd[g];
            r_dt[g+1] <= r_dt[g]; r_dh[g+1] <= r_dh[g]; r_db[g+1] <= r_db[g];
            if (w_r >= {2'b0, r_dd[g]}) begin
                r_dr[g+1] <= 33'(w_r - {2'b0, r_dd[g]});
                r_dq[g+1] <= {r_dq[g][31:0], 1'b1};
            end else begin
                r_dr[g+1] <= w_r[32:0];
                r_dq[g+1] <= {r_dq[g][31:0], 1'b0};
            end
        end
    end endgenerate

    // Last bit of quotient, then correction products
    logic [31:0] r8_t, r8_pr, r8_div; logic [16:0] r8_h;
    logic [33:0] w_rl; logic [32:0] w_ql;
    assign w_rl = {r_dr[DIV_STEPS], r_dn[DIV_STEPS][0]};
    assign w_ql = {r_dq[DIV_STEPS][31:0], (w_rl >= {2'b0, r_dd[DIV_STEPS]})};
    always_ff @(posedge i_clk) if (w_adv) begin
        r8_t <= r_dt[DIV_STEPS]; r8_h <= r_dh[DIV_STEPS];
        r8_div <= r_dd[DIV_STEPS];
        r8_pr <= r_db[DIV_STEPS] ? {w_ql[30:0], 1'b0} : w_ql[31:0];
    end

    logic [31:0] r9_t, r9_pr, r9_div, r9_a, r9_b; logic [16:0] r9_h;
    always_ff @(posedge i_clk) if (w_adv) begin
        r9_t <= r8_t; r9_h <= r8_h; r9_pr <= r8_pr; r9_div <= r8_div;
        r9_a <= ((r8_pr >> 3) * (r8_pr >> 3)) >> 13;
        r9_b <= sar((r8_pr >> 2) * p8, 13);
    end

    // Output register
    logic [31:0] w_a;
    assign w_a = sar(p9 * r9_a, 12);
    always_ff @(posedge i_clk) if (w_adv) begin
        o_res.temperature_centi <= r9_t[23:0];
        o_res.humidity_q10      <= r9_h;
        o_res.pressure_invalid  <= (r9_div == '0);
        o_res.pressure_pa <= (r9_div == '0) ? '0
                             : r9_pr + sar(w_a + r9_b + p7, 4);
    end
endmodule
`default_nettype wire

// ===== design/environmental_sensor_compensation_top.sv =====
`default_nettype none
// Channel  | dir | fields (low bit first)
// s_axis   | in  | tdata: raw_temperature[19:0] raw_pressure[39:20] raw_humidity[55:40]
// m_axis   | out | tdata: temperature_centi[23:0] pressure_pa[55:24]
//          |     |        pressure_invalid[56] humidity_q10[73:57]
// cfg      | in  | index 0..4, data 64 bits
// One frame per cycle sustained while m_axis accepts; from input to result
// handshake a frame passes one queue entry, eight stages ahead of the 32-stage
// restoring divider for pressure and three after it. A 4-entry queue sits ahead of
// the pipeline. Reset clears calibration and all valid flags. A stall on
// m_axis freezes the whole pipeline; the queue then fills and lowers tready.
module environmental_sensor_compensation_top
    import esc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // raw_temperature, raw_pressure, raw_humidity
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata   // temp, pressure, invalid, humidity, pad
);
    t_raw w_in, w_q;
    t_cal w_cal;
    t_res w_res;
    logic w_qv, w_qr;

    assign w_in.raw_temperature = s_axis_tdata[19:0];
    assign w_in.raw_pressure    = s_axis_tdata[39:20];
    assign w_in.raw_humidity    = s_axis_tdata[55:40];

    esc_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_raw(w_in),
        .o_cal(w_cal), .o_valid(w_qv), .i_ready(w_qr), .o_raw(w_q)
    );

    esc_back u_back (
        .i_clk, .i_rst_n, .i_cal(w_cal),
        .i_valid(w_qv), .o_ready(w_qr), .i_raw(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.humidity_q10, w_res.pressure_invalid,
                           w_res.pressure_pa, w_res.temperature_centi};
endmodule
`default_nettype wire

// ===== design/esc_checker.sv =====
`default_nettype none
module esc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata
);
    // Invalid pressure always reads zero
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[56] |-> m_axis_tdata[55:24] == 32'd0)
        else $error("invalid pressure not zero");
    // Humidity never exceeds 100 percent
    a_hum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[73:57] <= 17'd102400)
        else $error("humidity out of range");
    // Held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // No output right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind environmental_sensor_compensation_top esc_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
    import esc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned SETTLE      = 80;
    localparam logic [2:0]  REG_UNUSED  = 3'd7;
    localparam logic [2:0]  REG_SPARE   = 3'd5;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;  // raw_temperature[19:0] raw_pressure[39:20] raw_humidity[55:40]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;  // temperature_centi[23:0] pressure_pa[55:24]
                                // pressure_invalid[56] humidity_q10[73:57]

    // Calibration shadow kept by the predictor
    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_c;
    logic [63:0] cal_hum;

    t_res        pending_q[$];
    int unsigned error_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    environmental_sensor_compensation_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        logic signed [31:0] sv;
        sv = v;
        return sv >>> s;
    endfunction

    // Signed slice of a calibration word, widened to 32 bits
    function automatic logic [31:0] sslice(input logic [63:0] r, input int unsigned lo,
                                           input int unsigned n);
        logic [31:0] mask;
        logic [31:0] v;
        mask = (32'd1 << n) - 32'd1;
        v = 32'(r >> lo) & mask;
        if (v[n-1]) begin
            v = v | ~mask;
        end
        return v;
    endfunction

    function automatic logic [31:0] uslice(input logic [63:0] r, input int unsigned lo,
                                           input int unsigned n);
        return 32'(r >> lo) & ((32'd1 << n) - 32'd1);
    endfunction

    // Compensate one raw frame against the current calibration
    function automatic t_res compensate(input t_raw raw);
        logic [31:0] adc_t, adc_p, adc_h;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, d, q, x, fine, temp, pres, hum;
        t_res res;
        adc_t = 32'(raw.raw_temperature);
        adc_p = 32'(raw.raw_pressure);
        adc_h = 32'(raw.raw_humidity);
        t1 = uslice(cal_temp, 0, 16);
        t2 = sslice(cal_temp, 16, 16);
        t3 = sslice(cal_temp, 32, 16);
        p1 = uslice(cal_press_a, 0, 16);
        p2 = sslice(cal_press_a, 16, 16);
        p3 = sslice(cal_press_a, 32, 16);
        p4 = sslice(cal_press_a, 48, 16);
        p5 = sslice(cal_press_b, 0, 16);
        p6 = sslice(cal_press_b, 16, 16);
        p7 = sslice(cal_press_b, 32, 16);
        p8 = sslice(cal_press_b, 48, 16);
        p9 = sslice(64'(cal_press_c), 0, 16);
        h1 = uslice(cal_hum, 0, 8);
        h2 = sslice(cal_hum, 8, 16);
        h3 = uslice(cal_hum, 24, 8);
        h4 = sslice(cal_hum, 32, 12);
        h5 = sslice(cal_hum, 44, 12);
        h6 = sslice(cal_hum, 56, 8);
        res.pressure_invalid = 1'b0;

        // temperature and the shared fine term
        x = ((adc_t >> 3) - (t1 << 1)) * t2;
        a = asr32(x, 11);
        d = (adc_t >> 4) - t1;
        x = d * d;
        x = asr32(x, 12) * t3;
        b = asr32(x, 14);
        fine = a + b;
        x = fine * 32'd5 + 32'd128;
        temp = asr32(x, 8);

        // pressure
        a = asr32(fine, 1) - 32'd64000;
        q = asr32(a, 2) * asr32(a, 2);
        b = asr32(q, 11) * p6;
        x = (a * p5) << 1;
        b = b + x;
        b = asr32(b, 2) + (p4 << 16);
        x = p3 * asr32(q, 13);
        d = p2 * a;
        x = asr32(x, 3) + asr32(d, 1);
        a = asr32(x, 18);
        x = (32'd32768 + a) * p1;
        a = asr32(x, 15);
        if (a == 32'd0) begin
            pres = 32'd0;
            res.pressure_invalid = 1'b1;
        end else begin
            pres = ((32'd1048576 - adc_p) - asr32(b, 12)) * 32'd3125;
            if (pres < 32'h8000_0000) begin
                pres = (pres << 1) / a;
            end else begin
                pres = (pres / a) * 32'd2;
            end
            x = (pres >> 3) * (pres >> 3);
            x = p9 * (x >> 13);
            a = asr32(x, 12);
            x = (pres >> 2) * p8;
            b = asr32(x, 13);
            x = a + b + p7;
            pres = pres + asr32(x, 4);
        end

        // humidity
        hum = fine - 32'd76800;
        x = ((adc_h << 14) - (h4 << 20) - (h5 * hum)) + 32'd16384;
        a = asr32(x, 15);
        x = hum * h6;
        d = hum * h3;
        x = asr32(x, 10) * (asr32(d, 11) + 32'd32768);
        b = asr32(x, 10) + 32'd2097152;
        x = b * h2 + 32'd8192;
        b = asr32(x, 14);
        hum = a * b;
        q = asr32(hum, 15);
        x = q * q;
        x = asr32(x, 7) * h1;
        hum = hum - asr32(x, 4);
        if (hum[31]) begin
            hum = 32'd0;
        end
        if (hum > 32'd419430400) begin
            hum = 32'd419430400;
        end

        res.temperature_centi = temp[23:0];
        res.pressure_pa       = pres;
        res.humidity_q10      = hum[28:12];
        return res;
    endfunction

    // Write one calibration register and mirror it
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_TEMP: cal_temp    = value[47:0];
            REG_PA:   cal_press_a = value;
            REG_PB:   cal_press_b = value;
            REG_PC:   cal_press_c = value[15:0];
            REG_HUM:  cal_hum     = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [47:0] tc, input logic [63:0] pa,
                            input logic [63:0] pb, input logic [15:0] pc,
                            input logic [63:0] hc);
        write_reg(REG_TEMP, 64'(tc));
        write_reg(REG_PA, pa);
        write_reg(REG_PB, pb);
        write_reg(REG_PC, {48'(0), pc});
        write_reg(REG_HUM, hc);
    endtask

    // Typical factory calibration set
    task automatic load_typical_cal();
        load_cal({16'(-1000), 16'(26435), 16'(27504)},
                 {16'(2855), 16'(3024), 16'(-10685), 16'(36477)},
                 {16'(-14600), 16'(15500), 16'(-7), 16'(140)},
                 16'(6000),
                 {8'(30), 12'(50), 12'(313), 8'(0), 16'(362), 8'(75)});
    endtask

    // Typical set with random perturbation, or a fully random one
    task automatic load_random_cal();
        if ($urandom_range(3) == 0) begin
            load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     16'($urandom), {$urandom, $urandom});
        end else begin
            load_cal({16'(-1000 + int'($urandom_range(2000))),
                      16'(24000 + $urandom_range(5000)),
                      16'(26000 + $urandom_range(4000))},
                     {16'(2000 + $urandom_range(2000)), 16'(2500 + $urandom_range(1000)),
                      16'(-11000 + int'($urandom_range(1000))),
                      16'(34000 + $urandom_range(5000))},
                     {16'(-15000 + int'($urandom_range(1000))),
                      16'(14000 + $urandom_range(3000)),
                      16'(-20 + int'($urandom_range(40))), 16'($urandom_range(300))},
                     16'(4000 + $urandom_range(4000)),
                     {8'($urandom_range(40)), 12'($urandom_range(100)),
                      12'(250 + $urandom_range(150)), 8'($urandom_range(5)),
                      16'(300 + $urandom_range(150)), 8'($urandom_range(100))});
        end
    endtask

    // Offer one frame and hold it until accepted; valid stays high afterwards unless a random idle gap drops it
    task automatic send_frame(input t_raw raw);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw.raw_humidity, raw.raw_pressure, raw.raw_temperature};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_q.push_back(compensate(raw));
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 56'({$urandom, $urandom});
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_raw(input logic [19:0] rt, input logic [19:0] rp,
                            input logic [15:0] rh);
        t_raw raw;
        raw.raw_temperature = rt;
        raw.raw_pressure    = rp;
        raw.raw_humidity    = rh;
        send_frame(raw);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_reset_calibration();
        // zero calibration gives a zero divisor
        send_raw(20'd0, 20'd0, 16'd0);
        send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_raw(20'd519888, 20'd415148, 16'd27000);
        drain();
    endtask

    task automatic test_directed();
        load_typical_cal();
        send_raw(20'd519888, 20'd415148, 16'd27000);
        send_raw(20'd0, 20'd0, 16'd0);
        send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_raw(20'd0, 20'hFFFFF, 16'hFFFF);
        send_raw(20'hFFFFF, 20'd0, 16'd0);
        send_raw(20'h55555, 20'hAAAAA, 16'h5555);
        send_raw(20'hAAAAA, 20'h55555, 16'hAAAA);
        drain();
        // index beyond the register map must be ignored
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_SPARE, 64'h0);
        send_raw(20'd519888, 20'd415148, 16'd27000);
        drain();
        // extreme slopes push temperature out of its 24-bit range
        load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_raw(20'hFFFFF, 20'd0, 16'hFFFF);
        send_raw(20'd0, 20'hFFFFF, 16'd0);
        send_raw(20'h80000, 20'h80000, 16'h8000);
        drain();
        load_cal({16'h8000, 16'h8000, 16'hFFFF}, 64'h8000_8000_8000_FFFF,
                 64'h8000_8000_8000_8000, 16'h8000, 64'h80_800_800_FF_8000_FF);
        send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_raw(20'd0, 20'd0, 16'd0);
        send_raw(20'd123456, 20'd654321, 16'd40000);
        drain();
        // humidity clamps at both ends
        load_cal({16'(-1000), 16'(26435), 16'(27504)},
                 {16'(2855), 16'(3024), 16'(-10685), 16'(36477)},
                 {16'(-14600), 16'(15500), 16'(-7), 16'(140)},
                 16'(6000), {8'(30), 12'(50), 12'(0), 8'(0), 16'(30000), 8'(0)});
        send_raw(20'd519888, 20'd415148, 16'hFFFF);
        send_raw(20'd519888, 20'd415148, 16'd0);
        drain();
    endtask

    task automatic test_backpressure();
        load_typical_cal();
        send_idle_pct = 0;
        hold_left = 400;
        repeat (80) begin
            send_raw(20'($urandom), 20'($urandom), 16'($urandom));
        end
        drain();
    endtask

    task automatic test_random_frames(input int unsigned s_pct, input int unsigned r_pct,
                                      input int unsigned count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 115 == 0) begin
                drain();
                load_random_cal();
            end
            if ($urandom_range(7) == 0) begin
                send_raw(20'($urandom), 20'($urandom), 16'($urandom));
            end else begin
                send_raw(20'(480000 + $urandom_range(80000)),
                         20'(300000 + $urandom_range(200000)), 16'($urandom));
            end
        end
        drain();
    endtask

    // Receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $error("result with no frame pending: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata[23:0] !== want.temperature_centi) begin
                    $error("temperature_centi: expected %h, got %h",
                           want.temperature_centi, m_axis_tdata[23:0]);
                    error_count++;
                end
                if (m_axis_tdata[55:24] !== want.pressure_pa) begin
                    $error("pressure_pa: expected %h, got %h",
                           want.pressure_pa, m_axis_tdata[55:24]);
                    error_count++;
                end
                if (m_axis_tdata[56] !== want.pressure_invalid) begin
                    $error("pressure_invalid: expected %b, got %b",
                           want.pressure_invalid, m_axis_tdata[56]);
                    error_count++;
                end
                if (m_axis_tdata[73:57] !== want.humidity_q10) begin
                    $error("humidity_q10: expected %h, got %h",
                           want.humidity_q10, m_axis_tdata[73:57]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_TEMP;
        i_cfg_data    <= 64'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 56'd0;
        cal_temp      = 48'd0;
        cal_press_a   = 64'd0;
        cal_press_b   = 64'd0;
        cal_press_c   = 16'd0;
        cal_hum       = 64'd0;
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_calibration();
        test_directed();
        test_backpressure();
        test_random_frames(30, 66, 460);
        test_random_frames(66, 30, 460);
        test_random_frames(0, 0, 460);

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
